[design/vsr_pkg.sv]
// Shared types and constants for the vicinity system-information response parser.
package vsr_pkg;

  localparam int UID_BYTES = 8;
  localparam int UID_W     = UID_BYTES * 8;
  localparam int UIDX_W    = $clog2(UID_BYTES);

  // response flags byte
  localparam int RESP_ERR_BIT = 0;

  // information flags byte
  localparam int INFO_DSFID_BIT = 0;
  localparam int INFO_AFI_BIT   = 1;
  localparam int INFO_SIZE_BIT  = 2;
  localparam int INFO_ICREF_BIT = 3;

  // sticky status bits
  localparam int SEEN_ERR_BIT  = 0;
  localparam int SEEN_DONE_BIT = 1;
  localparam int SEEN_SIZE_BIT = 2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
    logic       extended_mode;
  } vsr_in_t;

  typedef struct packed {
    logic             parse_ok;
    logic [UID_W-1:0] tag_uid;
    logic [16:0]      num_blocks;
    logic [8:0]       blk_bytes;
    logic             size_present;
    logic             used_extended;
  } vsr_out_t;

endpackage

[design/vsr_step.sv]
// Byte-at-a-time parse state machine; gives the result word for the current byte.
module vsr_step
  import vsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  vsr_in_t  in_word,
  output vsr_out_t res
);

  typedef enum logic [3:0] {
    PH_RESP  = 4'd0,
    PH_INFO  = 4'd1,
    PH_UID   = 4'd2,
    PH_DSFID = 4'd3,
    PH_AFI   = 4'd4,
    PH_CNTLO = 4'd5,
    PH_CNTHI = 4'd6,
    PH_BSIZE = 4'd7,
    PH_ICREF = 4'd8,
    PH_DONE  = 4'd9,
    PH_ERR   = 4'd10
  } phase_t;

  localparam logic [UIDX_W-1:0] UID_LAST = UIDX_W'(UID_BYTES - 1);

  phase_t            phase_r, phase_nxt;
  logic [UIDX_W-1:0] uidx_r, uidx_nxt;
  logic [3:0]        info_r, info_nxt;
  logic [UID_W-1:0]  uid_r, uid_nxt;
  logic [15:0]       cnt_r, cnt_nxt;
  logic [7:0]        bsz_r, bsz_nxt;
  logic [2:0]        seen_r, seen_nxt;
  logic              ext_r, ext_nxt;
  logic              uid_done;
  logic              size_ok;

  function automatic phase_t next_field(input phase_t from, input logic [3:0] info);
    phase_t nf;
    nf = PH_DONE;
    if (from < PH_ICREF && info[INFO_ICREF_BIT]) nf = PH_ICREF;
    if (from < PH_CNTLO && info[INFO_SIZE_BIT])  nf = PH_CNTLO;
    if (from < PH_AFI   && info[INFO_AFI_BIT])   nf = PH_AFI;
    if (from < PH_DSFID && info[INFO_DSFID_BIT]) nf = PH_DSFID;
    return nf;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    uidx_nxt  = uidx_r;
    info_nxt  = info_r;
    uid_nxt   = uid_r;
    cnt_nxt   = cnt_r;
    bsz_nxt   = bsz_r;
    seen_nxt  = seen_r;
    ext_nxt   = ext_r;
    case (phase_r)
      PH_RESP: begin
        ext_nxt = in_word.extended_mode;
        if (in_word.byte_value[RESP_ERR_BIT]) begin
          seen_nxt[SEEN_ERR_BIT] = 1'b1;
          phase_nxt = PH_ERR;
        end else begin
          phase_nxt = PH_INFO;
        end
      end
      PH_INFO: begin
        info_nxt  = in_word.byte_value[3:0];
        uidx_nxt  = '0;
        phase_nxt = PH_UID;
      end
      PH_UID: begin
        uid_nxt[{uidx_r, 3'b000} +: 8] = uid_r[{uidx_r, 3'b000} +: 8] | in_word.byte_value;
        if (uidx_r == UID_LAST) begin
          uidx_nxt  = '0;
          phase_nxt = next_field(PH_UID, info_r);
        end else begin
          uidx_nxt = uidx_r + 1'b1;
        end
      end
      PH_DSFID, PH_AFI, PH_ICREF: begin
        phase_nxt = next_field(phase_r, info_r);
      end
      PH_CNTLO: begin
        cnt_nxt   = {8'h00, in_word.byte_value};
        phase_nxt = ext_r ? PH_CNTHI : PH_BSIZE;
      end
      PH_CNTHI: begin
        cnt_nxt   = {in_word.byte_value, cnt_r[7:0]};
        phase_nxt = PH_BSIZE;
      end
      PH_BSIZE: begin
        bsz_nxt = in_word.byte_value;
        seen_nxt[SEEN_SIZE_BIT] = 1'b1;
        phase_nxt = next_field(PH_BSIZE, info_r);
      end
      default: begin
      end
    endcase
    if (phase_nxt == PH_DONE) seen_nxt[SEEN_DONE_BIT] = 1'b1;
  end

  assign uid_done = phase_nxt inside {[PH_DSFID:PH_DONE]};
  assign size_ok  = seen_nxt[SEEN_SIZE_BIT];

  always_comb begin
    res.parse_ok      = seen_nxt[SEEN_DONE_BIT] & ~seen_nxt[SEEN_ERR_BIT];
    res.tag_uid       = uid_done ? uid_nxt : '0;
    res.num_blocks    = size_ok ? ({1'b0, cnt_nxt} + 17'd1) : '0;
    res.blk_bytes     = size_ok ? ({1'b0, bsz_nxt} + 9'd1) : '0;
    res.size_present  = size_ok;
    res.used_extended = ext_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_word.last_byte)) begin
      phase_r <= PH_RESP;
      uidx_r  <= '0;
      info_r  <= '0;
      uid_r   <= '0;
      cnt_r   <= '0;
      bsz_r   <= '0;
      seen_r  <= '0;
      ext_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      uidx_r  <= uidx_nxt;
      info_r  <= info_nxt;
      uid_r   <= uid_nxt;
      cnt_r   <= cnt_nxt;
      bsz_r   <= bsz_nxt;
      seen_r  <= seen_nxt;
      ext_r   <= ext_nxt;
    end
  end

endmodule

[design/vicinity_sysinfo_response_parser.sv]
// Top level of the vicinity-card Get System Information response parser.
//
// Input channel (in_valid/in_ready/in_data): one response byte per word, with
// last_byte marking the final byte and extended_mode taken on the first byte.
// Output channel (out_valid/out_ready/out_data): one result word per response,
// produced from the word marked last.
// Throughput: one input word per cycle while no result waits on a low out_ready.
// The parse state machine updates on every accepted word; the result is
// registered, so it appears on out_valid the cycle after the last byte is accepted.
// The single output register is the only buffer: while a result waits and
// out_ready is low, in_ready drops; as soon as the result is taken (even in the
// same cycle) a new byte is accepted.
// Reset (rst_n low, synchronous) returns the parser to expect a response flags
// byte and empties the output register. After each result the parser clears
// itself for the next response.
module vicinity_sysinfo_response_parser
  import vsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  vsr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output vsr_out_t out_data
);

  logic     accept;
  logic     out_valid_r;
  vsr_out_t out_data_r;
  vsr_out_t res;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  vsr_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_data),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_data.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_byte) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/vsr_checker.sv]
// Port-level checks for the response parser, bound to the top level.
module vsr_checker
  import vsr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input vsr_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input vsr_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_byte |=> out_valid)
    else $error("no result after last byte");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

  a_size_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.size_present
                   ? (out_data.num_blocks != '0 && out_data.blk_bytes != '0)
                   : (out_data.num_blocks == '0 && out_data.blk_bytes == '0)))
    else $error("memory size fields inconsistent with size_present");

endmodule

bind vicinity_sysinfo_response_parser vsr_checker u_vsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[sim/vicinity_sysinfo_response_parser_tb.sv]
// Self-checking testbench for the vicinity system-information response parser.
`timescale 1ns / 1ps

module vicinity_sysinfo_response_parser_tb;
  import vsr_pkg::*;

  localparam int RANDOM_WORDS = 1250;
  localparam int STALL_LIMIT  = 1000;

  typedef enum logic [3:0] {
    P_RESP, P_INFO, P_UID, P_DSFID, P_AFI, P_CNTLO, P_CNTHI, P_BSIZE, P_ICREF, P_DONE, P_ERR
  } phase_t;

  typedef struct {
    vsr_in_t  w;
    bit       fixed;
    vsr_out_t want;
  } stim_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  vsr_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  vsr_out_t out_data;

  vsr_out_t pending_results[$];
  int       mismatches = 0;
  int       words_sent = 0;
  int       responses = 0;
  int       results_seen = 0;
  int       ok_seen = 0;
  int       size_seen = 0;
  int       idle_cycles = 0;
  bit       tx_burst = 1'b0;
  bit       rx_burst = 1'b0;

  // parser shadow state
  phase_t           ph        = P_RESP;
  int               uid_idx   = 0;
  logic [3:0]       info_bits = '0;
  logic [UID_W-1:0] uid_acc   = '0;
  logic [15:0]      cnt_acc   = '0;
  logic [7:0]       bsz_acc   = '0;
  bit               seen_err  = 1'b0;
  bit               seen_done = 1'b0;
  bit               seen_size = 1'b0;
  bit               ext_latch = 1'b0;

  vicinity_sysinfo_response_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic phase_t next_opt(phase_t from);
    if (from < P_DSFID && info_bits[INFO_DSFID_BIT]) return P_DSFID;
    if (from < P_AFI && info_bits[INFO_AFI_BIT]) return P_AFI;
    if (from < P_CNTLO && info_bits[INFO_SIZE_BIT]) return P_CNTLO;
    if (from < P_ICREF && info_bits[INFO_ICREF_BIT]) return P_ICREF;
    return P_DONE;
  endfunction

  function automatic void parse_byte(input vsr_in_t w, output bit has_res,
                                     output vsr_out_t res);
    res = '0;
    has_res = 1'b0;
    case (ph)
      P_RESP: begin
        ext_latch = w.extended_mode;
        if (w.byte_value[RESP_ERR_BIT]) begin
          seen_err = 1'b1;
          ph = P_ERR;
        end else begin
          ph = P_INFO;
        end
      end
      P_INFO: begin
        info_bits = w.byte_value[3:0];
        uid_idx = 0;
        ph = P_UID;
      end
      P_UID: begin
        uid_acc[uid_idx*8 +: 8] = w.byte_value;
        if (uid_idx == UID_BYTES - 1) begin
          uid_idx = 0;
          ph = next_opt(P_UID);
        end else begin
          uid_idx++;
        end
      end
      P_DSFID, P_AFI, P_ICREF: ph = next_opt(ph);
      P_CNTLO: begin
        cnt_acc = {8'h00, w.byte_value};
        ph = ext_latch ? P_CNTHI : P_BSIZE;
      end
      P_CNTHI: begin
        cnt_acc[15:8] = w.byte_value;
        ph = P_BSIZE;
      end
      P_BSIZE: begin
        bsz_acc = w.byte_value;
        seen_size = 1'b1;
        ph = next_opt(P_BSIZE);
      end
      default: ;
    endcase
    if (ph == P_DONE) seen_done = 1'b1;
    if (w.last_byte) begin
      has_res = 1'b1;
      res.parse_ok      = seen_done && !seen_err;
      res.tag_uid       = (ph >= P_DSFID && ph <= P_DONE) ? uid_acc : '0;
      res.num_blocks    = seen_size ? {1'b0, cnt_acc} + 17'd1 : '0;
      res.blk_bytes     = seen_size ? {1'b0, bsz_acc} + 9'd1 : '0;
      res.size_present  = seen_size;
      res.used_extended = ext_latch;
      ph        = P_RESP;
      uid_idx   = 0;
      info_bits = '0;
      uid_acc   = '0;
      cnt_acc   = '0;
      bsz_acc   = '0;
      seen_err  = 1'b0;
      seen_done = 1'b0;
      seen_size = 1'b0;
      ext_latch = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR t=%0t %s: got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // drive one word; predict on acceptance
  task automatic send_word(vsr_in_t w, bit fixed, vsr_out_t want);
    int       gap;
    bit       got;
    vsr_out_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    parse_byte(w, got, pred);
    if (got) pending_results.push_back(fixed ? want : pred);
  endtask

  task automatic gen_response();
    logic [7:0] resp[$];
    logic [7:0] flags0;
    logic [7:0] info;
    bit         ext;
    int         kind;
    int         keep;
    vsr_in_t    w;
    if ($urandom_range(0, 7) == 0) tx_burst = !tx_burst;
    kind = $urandom_range(0, 9);
    ext = 1'($urandom);
    flags0 = 8'($urandom);
    if (kind == 0) begin
      flags0[RESP_ERR_BIT] = 1'b1;
      resp.push_back(flags0);
      words_sent += 1;
      repeat ($urandom_range(0, 3)) resp.push_back(8'($urandom));
    end else begin
      flags0[RESP_ERR_BIT] = 1'b0;
      info = 8'($urandom);
      resp.push_back(flags0);
      resp.push_back(info);
      repeat (UID_BYTES) resp.push_back(8'($urandom));
      if (info[INFO_DSFID_BIT]) resp.push_back(8'($urandom));
      if (info[INFO_AFI_BIT]) resp.push_back(8'($urandom));
      if (info[INFO_SIZE_BIT]) begin
        resp.push_back(8'($urandom));
        if (ext) resp.push_back(8'($urandom));
        resp.push_back(8'($urandom));
      end
      if (info[INFO_ICREF_BIT]) resp.push_back(8'($urandom));
      if (kind <= 2) begin
        keep = $urandom_range(1, resp.size() - 1);
        while (resp.size() > keep) void'(resp.pop_back());
      end
      words_sent += resp.size();
      if (kind > 2 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) resp.push_back(8'($urandom));
      end
    end
    foreach (resp[i]) begin
      w.byte_value    = resp[i];
      w.last_byte     = (i == resp.size() - 1);
      w.extended_mode = (i == 0) ? ext : 1'($urandom);
      send_word(w, 1'b0, '0);
    end
    responses++;
  endtask

  initial begin
    stim_row_t rows[$];
    bit        paused;
    paused = 1'b0;
    // error flag, then a byte that must be ignored
    rows.push_back('{'{8'h01, 1'b0, 1'b1}, 1'b0, '0});
    rows.push_back('{'{8'hAA, 1'b1, 1'b0}, 1'b1, '{1'b0, '0, '0, '0, 1'b0, 1'b1}});
    // flags byte alone
    rows.push_back('{'{8'h00, 1'b1, 1'b0}, 1'b1, '{1'b0, '0, '0, '0, 1'b0, 1'b0}});
    // every field present, extended count, maximum values
    rows.push_back('{'{8'hFE, 1'b0, 1'b1}, 1'b0, '0});
    rows.push_back('{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0});
    for (int k = 0; k < UID_BYTES; k++) rows.push_back('{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h00, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h00, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h00, 1'b1, 1'b0}, 1'b1,
                     '{1'b1, {UID_W{1'b1}}, 17'h10000, 9'h100, 1'b1, 1'b1}});
    // truncated inside the UID
    rows.push_back('{'{8'h00, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h04, 1'b0, 1'b1}, 1'b0, '0});
    rows.push_back('{'{8'h12, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h34, 1'b1, 1'b1}, 1'b0, '0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) begin
      send_word(rows[i].w, rows[i].fixed, rows[i].want);
      if (rows[i].w.last_byte) responses++;
    end
    while (words_sent < RANDOM_WORDS) begin
      if (!paused && words_sent >= RANDOM_WORDS / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      gen_response();
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d responses (%0d parsed words), checked %0d results.",
             responses, words_sent + rows.size(), results_seen);
    $display("Results: %0d parsed ok, %0d with memory size, %0d mismatches.",
             ok_seen, size_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int       stall;
    vsr_out_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", out_data.tag_uid, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.parse_ok)     ok_seen++;
        if (out_data.size_present) size_seen++;
        if (out_data.parse_ok !== want.parse_ok)
          report_mismatch("parse_ok", out_data.parse_ok, want.parse_ok);
        if (out_data.tag_uid !== want.tag_uid)
          report_mismatch("tag_uid", out_data.tag_uid, want.tag_uid);
        if (out_data.num_blocks !== want.num_blocks)
          report_mismatch("num_blocks", out_data.num_blocks, want.num_blocks);
        if (out_data.blk_bytes !== want.blk_bytes)
          report_mismatch("blk_bytes", out_data.blk_bytes, want.blk_bytes);
        if (out_data.size_present !== want.size_present)
          report_mismatch("size_present", out_data.size_present, want.size_present);
        if (out_data.used_extended !== want.used_extended)
          report_mismatch("used_extended", out_data.used_extended, want.used_extended);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
